// ----- design/ncoe_pkg.sv -----
`timescale 1ns / 1ps

package ncoe_pkg;

  localparam int MAX_AXES   = 4;
  localparam int COORD_BITS = 16;
  localparam int AXIS_W     = 2;
  localparam int RANK_W     = 3;
  localparam int KIND_W     = 3;
  localparam int DIM_W      = 16;
  localparam int ELEM_W     = 64;
  localparam int ORD_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM3 = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_INT8    = 3'd0,
    KIND_INT16   = 3'd1,
    KIND_INT32   = 3'd2,
    KIND_INT64   = 3'd3,
    KIND_FLOAT32 = 3'd4,
    KIND_FLOAT64 = 3'd5,
    KIND_HALF    = 3'd6
  } elem_kind_t;

  typedef logic [COORD_BITS-1:0] coord_t;

  // snapshot of one nonzero element handed to the serializer
  typedef struct packed {
    logic [RANK_W-1:0]           rank;
    coord_t [MAX_AXES-1:0]       coord;
    logic [ORD_W-1:0]            ordinal;
  } item_t;

endpackage

// ----- design/ncoe_in_if.sv -----
`timescale 1ns / 1ps

interface ncoe_in_if
  import ncoe_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] elem_value;
  logic              start_of_tensor;

  modport source (output valid, output elem_value, output start_of_tensor, input ready);
  modport sink   (input valid, input elem_value, input start_of_tensor, output ready);
endinterface

// ----- design/ncoe_out_if.sv -----
`timescale 1ns / 1ps

interface ncoe_out_if
  import ncoe_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [AXIS_W-1:0] axis_index;
  logic [15:0]       coordinate;
  logic [ORD_W-1:0]  nonzero_ordinal;
  logic              last_of_run;

  modport source (output valid, output axis_index, output coordinate,
                  output nonzero_ordinal, output last_of_run, input ready);
  modport sink   (input valid, input axis_index, input coordinate,
                  input nonzero_ordinal, input last_of_run, output ready);
endinterface

// ----- design/ncoe_tracker.sv -----
`timescale 1ns / 1ps

module ncoe_tracker
  import ncoe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  accept,
  input  logic [ELEM_W-1:0]     elem_value,
  input  logic                  start_of_tensor,
  output logic                  item_load,
  output item_t                 item
);

  logic [RANK_W-1:0]            rank_r;
  logic [KIND_W-1:0]            kind_r;
  logic [DIM_W-1:0]             dim_r [MAX_AXES];
  coord_t                       pos_r [MAX_AXES];
  logic [ORD_W-1:0]             tally_r;

  logic [RANK_W-1:0]            act_rank;
  coord_t                       pos_base [MAX_AXES];
  coord_t                       pos_nxt [MAX_AXES];
  logic [ORD_W-1:0]             tally_base;
  logic [ORD_W-1:0]             tally_nxt;
  logic                         nonzero;
  logic                         carry;
  logic [COORD_BITS:0]          pos_inc;
  logic [DIM_W-1:0]             ext;

  function automatic logic is_nonzero(input logic [ELEM_W-1:0] v,
                                      input logic [KIND_W-1:0] kind);
    logic res;
    case (kind)
      KIND_INT8:    res = |v[7:0];
      KIND_INT16:   res = |v[15:0];
      KIND_INT32:   res = |v[31:0];
      KIND_FLOAT32: res = |v[30:0];
      KIND_FLOAT64: res = |v[62:0];
      KIND_HALF:    res = |v[14:0];
      default:      res = |v;
    endcase
    return res;
  endfunction

  assign act_rank   = (rank_r > RANK_W'(MAX_AXES)) ? RANK_W'(MAX_AXES) : rank_r;
  assign nonzero    = is_nonzero(elem_value, kind_r);
  assign tally_base = start_of_tensor ? '0 : tally_r;
  assign item_load  = accept && (act_rank != '0) && nonzero;
  assign tally_nxt  = (item_load && (tally_base != '1)) ? tally_base + 1'b1 : tally_base;

  always_comb begin
    for (int d = 0; d < MAX_AXES; d++) begin
      pos_base[d] = start_of_tensor ? '0 : pos_r[d];
    end
  end

  always_comb begin
    item.rank    = act_rank;
    item.ordinal = tally_base;
    for (int d = 0; d < MAX_AXES; d++) begin
      item.coord[d] = pos_base[d];
    end
  end

  // ripple carry from the innermost axis in use outward
  always_comb begin
    carry   = 1'b1;
    pos_inc = '0;
    ext     = '0;
    for (int d = MAX_AXES - 1; d >= 0; d--) begin
      pos_nxt[d] = pos_base[d];
      if ((d < int'(act_rank)) && carry) begin
        pos_inc = {1'b0, pos_base[d]} + 1'b1;
        ext     = (dim_r[d] == '0) ? DIM_W'(1) : dim_r[d];
        if (pos_inc >= (COORD_BITS + 1)'(ext)) begin
          pos_nxt[d] = '0;
        end else begin
          pos_nxt[d] = pos_inc[COORD_BITS-1:0];
          carry      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r  <= RANK_W'(1);
      kind_r  <= KIND_INT8;
      tally_r <= '0;
      for (int d = 0; d < MAX_AXES; d++) begin
        dim_r[d] <= DIM_W'(1);
        pos_r[d] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RANK: rank_r   <= cfg_wdata[RANK_W-1:0];
          CFG_KIND: kind_r   <= cfg_wdata[KIND_W-1:0];
          CFG_DIM0: dim_r[0] <= cfg_wdata[DIM_W-1:0];
          CFG_DIM1: dim_r[1] <= cfg_wdata[DIM_W-1:0];
          CFG_DIM2: dim_r[2] <= cfg_wdata[DIM_W-1:0];
          CFG_DIM3: dim_r[3] <= cfg_wdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        tally_r <= tally_nxt;
        for (int d = 0; d < MAX_AXES; d++) begin
          pos_r[d] <= pos_nxt[d];
        end
      end
    end
  end

endmodule

// ----- design/ncoe_serializer.sv -----
`timescale 1ns / 1ps

module ncoe_serializer
  import ncoe_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_load,
  input  item_t         item,
  output logic          in_ready,
  ncoe_out_if.source    out_ch
);

  logic              item_valid_r;
  item_t             item_r;
  logic [AXIS_W-1:0] axis_r;
  logic              out_valid_r;
  logic [AXIS_W-1:0] axis_out_r;
  coord_t            coord_out_r;
  logic [ORD_W-1:0]  ord_out_r;
  logic              last_out_r;

  logic              out_free;
  logic              move;
  logic              is_last;

  assign out_free = !out_valid_r || out_ch.ready;
  assign move     = item_valid_r && out_free;
  assign is_last  = (RANK_W'(axis_r) + 1'b1) == item_r.rank;
  assign in_ready = !item_valid_r || (move && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      axis_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (item_load) begin
        item_valid_r <= 1'b1;
        axis_r       <= '0;
      end else if (move && is_last) begin
        item_valid_r <= 1'b0;
      end else if (move) begin
        axis_r <= axis_r + 1'b1;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      item_r <= item;
    end
    if (move) begin
      axis_out_r  <= axis_r;
      coord_out_r <= item_r.coord[axis_r];
      ord_out_r   <= item_r.ordinal;
      last_out_r  <= is_last;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.axis_index      = axis_out_r;
  assign out_ch.coordinate      = coord_out_r[15:0];
  assign out_ch.nonzero_ordinal = ord_out_r;
  assign out_ch.last_of_run     = last_out_r;

endmodule

// ----- design/nonzero_coordinate_emitter.sv -----
`timescale 1ns / 1ps

// channel   dir  payload                                            handshake
// in_ch     in   elem_value[63:0], start_of_tensor                  valid/ready
// out_ch    out  axis_index[1:0], coordinate[15:0],                 valid/ready
//                nonzero_ordinal[31:0], last_of_run
// cfg       in   cfg_index[2:0], cfg_wdata[15:0]                    cfg_we
//
// while out_ch is ready, one result leaves per cycle; a nonzero element of rank r
// yields r results, a zero element (or rank zero) yields nothing
// the pace is set by the serializer, which moves one axis per cycle unless out_ch stalls
// rst_n is synchronous; it restores the register defaults and clears
// coordinates, ordinal and both holding stages
// a stalled out_ch holds the result register; the next element is taken
// while the last axis of the current one moves to the output

module nonzero_coordinate_emitter
  import ncoe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ncoe_in_if.sink               in_ch,
  ncoe_out_if.source            out_ch
);

  logic  accept;
  logic  in_ready;
  logic  item_load;
  item_t item;

  // input transaction completes here
  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // coordinate counter, ordinal and nonzero test
  ncoe_tracker u_tracker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .accept          (accept),
    .elem_value      (in_ch.elem_value),
    .start_of_tensor (in_ch.start_of_tensor),
    .item_load       (item_load),
    .item            (item)
  );

  // one result per axis, outermost first, through the output register
  ncoe_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_load (item_load),
    .item      (item),
    .in_ready  (in_ready),
    .out_ch    (out_ch)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import ncoe_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SHAPES       = 9;
  localparam int ELEMS_PER_SHAPE = 25;
  localparam int MAX_GAP      = 50;

  // one coordinate transaction as it leaves the block
  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    coord_t            coord;
    logic [ORD_W-1:0]  ordinal;
    logic              last;
  } coord_result_t;

  // tracks the coordinate counter and nonzero tally, queues the coordinates due
  class nz_coord_tracker;
    logic [RANK_W-1:0] rank_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [DIM_W-1:0]  dim_reg [MAX_AXES];
    coord_t            axis_pos [MAX_AXES];
    logic [ORD_W-1:0]  tally;
    coord_result_t     coords_due [$];
    int                mismatches;

    function new();
      rank_reg   = RANK_W'(1);
      kind_reg   = KIND_INT8;
      for (int d = 0; d < MAX_AXES; d++) begin
        dim_reg[d]  = DIM_W'(1);
        axis_pos[d] = '0;
      end
      tally      = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_RANK: rank_reg = data[RANK_W-1:0];
        CFG_KIND: kind_reg = data[KIND_W-1:0];
        CFG_DIM0: dim_reg[0] = data[DIM_W-1:0];
        CFG_DIM1: dim_reg[1] = data[DIM_W-1:0];
        CFG_DIM2: dim_reg[2] = data[DIM_W-1:0];
        CFG_DIM3: dim_reg[3] = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function bit elem_nonzero(logic [ELEM_W-1:0] v);
      case (kind_reg)
        KIND_INT8:    return |v[7:0];
        KIND_INT16:   return |v[15:0];
        KIND_INT32:   return |v[31:0];
        KIND_FLOAT32: return |v[30:0];
        KIND_FLOAT64: return |v[62:0];
        KIND_HALF:    return |v[14:0];
        default:      return |v;
      endcase
    endfunction

    function void note_element(logic [ELEM_W-1:0] v, logic sot);
      int            r;
      int            d;
      int            ext;
      coord_result_t res;
      if (sot) begin
        for (d = 0; d < MAX_AXES; d++) axis_pos[d] = '0;
        tally = '0;
      end
      r = (int'(rank_reg) > MAX_AXES) ? MAX_AXES : int'(rank_reg);
      if (r == 0) return;
      if (elem_nonzero(v)) begin
        for (d = 0; d < r; d++) begin
          res.axis    = AXIS_W'(d);
          res.coord   = axis_pos[d];
          res.ordinal = tally;
          res.last    = (d == r - 1);
          coords_due.push_back(res);
        end
        if (tally != '1) tally = tally + 1'b1;
      end
      // ripple carry from the innermost axis in use
      for (d = r - 1; d >= 0; d--) begin
        ext = (dim_reg[d] == '0) ? 1 : int'(dim_reg[d]);
        if (int'(axis_pos[d]) + 1 >= ext) begin
          axis_pos[d] = '0;
        end else begin
          axis_pos[d] = axis_pos[d] + 1'b1;
          break;
        end
      end
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("ERROR %0t: %s", $realtime, msg);
    endtask

    task check_coord(coord_result_t got);
      coord_result_t exp;
      if (coords_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected coordinate axis=%0d coord=%0d ord=%0d last=%0b",
                                got.axis, got.coord, got.ordinal, got.last));
      end else begin
        exp = coords_due.pop_front();
        if (got.axis != exp.axis || got.coord != exp.coord ||
            got.ordinal != exp.ordinal || got.last != exp.last)
          flag_mismatch($sformatf(
            {"coordinate got axis=%0d coord=%0d ord=%0d last=%0b, ",
             "exp axis=%0d coord=%0d ord=%0d last=%0b"},
            got.axis, got.coord, got.ordinal, got.last,
            exp.axis, exp.coord, exp.ordinal, exp.last));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ncoe_in_if  in_ch ();
  ncoe_out_if out_ch ();

  nz_coord_tracker tracker;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              cycle_count = 0;

  nonzero_coordinate_emitter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // watchdog, generous against the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nonzero_coordinate_emitter test failed");
      $finish;
    end
  end

  // receiver: check each accepted coordinate, then pick ready for the next cycle
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        tracker.check_coord({out_ch.axis_index, out_ch.coordinate,
                             out_ch.nonzero_ordinal, out_ch.last_of_run});
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one register write per cycle; the caller lowers cfg_we after the last one
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic load_shape(logic [RANK_W-1:0] rank, logic [KIND_W-1:0] kind,
                            logic [DIM_W-1:0] d0, logic [DIM_W-1:0] d1,
                            logic [DIM_W-1:0] d2, logic [DIM_W-1:0] d3);
    put_reg(CFG_RANK, CFG_DATA_W'(rank));
    put_reg(CFG_KIND, CFG_DATA_W'(kind));
    put_reg(CFG_DIM0, d0);
    put_reg(CFG_DIM1, d1);
    put_reg(CFG_DIM2, d2);
    put_reg(CFG_DIM3, d3);
    cfg_we <= 1'b0;
  endtask

  // present one element, hold it until the transaction completes
  task automatic send_element(logic [ELEM_W-1:0] v, logic sot);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.elem_value      <= v;
    in_ch.start_of_tensor <= sot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_element(v, sot);
  endtask

  // block goes idle: all coordinates out, plus time for a trailing zero element
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (tracker.coords_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mix of zeros, sign-only patterns, bits above the kind's width and full noise
  function automatic logic [ELEM_W-1:0] random_elem();
    case ($urandom_range(7))
      0: return '0;
      1: return ELEM_W'(1) << $urandom_range(ELEM_W - 1);
      2: begin
        case ($urandom_range(4))
          0: return 64'h80;
          1: return 64'h8000;
          2: return 64'h8000_0000;
          3: return 64'h8000_0000_0000_0000;
          default: return 64'hFFFF_FFFF_FFFF_0000;
        endcase
      end
      3: return '1;
      4: return ELEM_W'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] random_extent();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 15) return '1;
    return DIM_W'($urandom_range(1, 4));
  endfunction

  initial begin
    logic [RANK_W-1:0] rank;
    tracker = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_wdata             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.elem_value      <= '0;
    in_ch.start_of_tensor <= 1'b0;
    out_ch.ready          <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 84;

    // register defaults: rank one, int8, unit extents; bits above int8 are ignored
    send_element(64'h0, 1'b0);
    send_element(64'h100, 1'b0);
    send_element(64'hFF, 1'b0);

    // float32: minus zero, nan, upper word only; zero extent and widest extent
    drain_results();
    load_shape(RANK_W'(4), KIND_FLOAT32, DIM_W'(2), DIM_W'(1), '0, '1);
    send_element(64'h8000_0000, 1'b1);
    send_element(64'h7FC0_0000, 1'b0);
    send_element(64'hFFFF_FFFF_0000_0000, 1'b0);
    send_element(64'h1, 1'b0);

    // float64 sign bit, counter carried over from the previous shape
    drain_results();
    load_shape(RANK_W'(2), KIND_FLOAT64, DIM_W'(3), DIM_W'(2), DIM_W'(1), DIM_W'(1));
    send_element(64'h8000_0000_0000_0000, 1'b0);
    send_element(64'h8000_0000_0000_0001, 1'b0);

    // 16-bit floats
    drain_results();
    load_shape(RANK_W'(3), KIND_HALF, '1, DIM_W'(2), DIM_W'(2), DIM_W'(1));
    send_element(64'h8000, 1'b1);
    send_element(64'h7C00, 1'b0);
    send_element(64'hFFFF_0000, 1'b0);

    drain_results();
    load_shape(RANK_W'(1), KIND_INT16, DIM_W'(4), DIM_W'(1), DIM_W'(1), DIM_W'(1));
    send_element(64'h1_0000, 1'b0);
    send_element(64'h8000, 1'b0);

    drain_results();
    load_shape(RANK_W'(2), KIND_INT32, DIM_W'(2), DIM_W'(2), DIM_W'(1), DIM_W'(1));
    send_element(64'h1_0000_0000, 1'b0);
    send_element(64'h8000_0000, 1'b0);

    // extents shrunk below the current positions: those axes wrap on advance
    drain_results();
    load_shape(RANK_W'(4), KIND_INT64, DIM_W'(1), DIM_W'(1), DIM_W'(1), DIM_W'(3));
    send_element(64'h8000_0000_0000_0000, 1'b0);
    send_element(64'h0, 1'b0);

    // rank zero emits nothing but a start still clears; unused kind code acts as int64
    drain_results();
    load_shape('0, KIND_W'(7), DIM_W'(2), DIM_W'(2), DIM_W'(2), DIM_W'(2));
    send_element('1, 1'b1);
    send_element(64'h1, 1'b0);

    // rank above four is clamped
    drain_results();
    load_shape(RANK_W'(7), KIND_W'(7), DIM_W'(2), DIM_W'(2), DIM_W'(2), DIM_W'(2));
    send_element(64'h8000_0000_0000_0000, 1'b0);
    send_element('1, 1'b0);

    // random shapes, each mostly one well-formed tensor stream
    for (int s = 0; s < SHAPES; s++) begin
      if (s == SHAPES / 3) begin
        send_idle_pct = 84;
        recv_idle_pct = 33;
      end else if (s == 2 * SHAPES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_results();
      if ($urandom_range(99) < 80) rank = RANK_W'($urandom_range(1, 4));
      else rank = RANK_W'($urandom_range(0, 7));
      load_shape(rank, KIND_W'($urandom_range(0, 7)), random_extent(), random_extent(),
                 random_extent(), random_extent());
      for (int i = 0; i < ELEMS_PER_SHAPE; i++) begin
        if (i == 0) send_element(random_elem(), $urandom_range(99) < 85);
        else send_element(random_elem(), $urandom_range(99) < 5);
      end
    end

    drain_results();
    if (tracker.mismatches == 0) begin
      $display("nonzero_coordinate_emitter test passed");
    end else begin
      $display("nonzero_coordinate_emitter test failed");
    end
    $finish;
  end

endmodule
